/* rtl/dfr_pkg.sv */
// Shared types, codes and constants of the typed-field packet deframer.
package dfr_pkg;

  localparam logic [15:0] MagicPacket = 16'hD731;
  localparam logic [15:0] MagicBatch  = 16'hD732;
  localparam logic [20:0] MaxBytesRst = 21'(1 << 20);
  localparam logic [20:0] CountSat    = 21'h1F_FFFF;
  localparam int unsigned ResDepth    = 4;
  localparam int unsigned ResPtrW     = $clog2(ResDepth);

  typedef enum logic [2:0] {
    KindPacket  = 3'd0,
    KindInt32   = 3'd1,
    KindInt64   = 3'd2,
    KindFloat   = 3'd3,
    KindStrHead = 3'd4,
    KindStrByte = 3'd5,
    KindVerdict = 3'd6
  } kind_e;

  typedef enum logic [3:0] {
    StOk        = 4'd0,
    StBadMagic  = 4'd1,
    StBadLength = 4'd2,
    StBadOpcode = 4'd3,
    StBadType   = 4'd4,
    StOverlong  = 4'd5,
    StTruncated = 4'd6,
    StTrailing  = 4'd7,
    StEmpty     = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    FtStr8  = 3'd0,
    FtInt32 = 3'd1,
    FtInt64 = 3'd2,
    FtFloat = 3'd3,
    FtStr16 = 3'd4
  } ftype_e;

  typedef enum logic [15:0] {
    PhMag0   = 16'h0001,
    PhMag1   = 16'h0002,
    PhBlen0  = 16'h0004,
    PhBlen1  = 16'h0008,
    PhPmag0  = 16'h0010,
    PhPmag1  = 16'h0020,
    PhOpc    = 16'h0040,
    PhCnt    = 16'h0080,
    PhFtype  = 16'h0100,
    PhVar    = 16'h0200,
    PhFloat  = 16'h0400,
    PhSlen0  = 16'h0800,
    PhSlen1  = 16'h1000,
    PhSbytes = 16'h2000,
    PhDone   = 16'h4000,
    PhDrop   = 16'h8000
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] value;
    logic [7:0]  field_count;
    status_e     status;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic vld0;
    logic vld1;
    res_t r0;
    res_t r1;
  } push_t;

  function automatic logic opcode_ok(input logic [7:0] id);
    opcode_ok = (id >= 8'd1  && id <= 8'd6)  || (id >= 8'd10 && id <= 8'd16) ||
                (id >= 8'd20 && id <= 8'd34) || (id >= 8'd40 && id <= 8'd46) ||
                (id >= 8'd60 && id <= 8'd86) || (id >= 8'd90 && id <= 8'd94);
  endfunction

endpackage

/* rtl/dfr_in_if.sv */
// Byte input channel: one datagram byte with its end flag per transaction.
interface dfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_datagram;

  modport source (output valid, output data_byte, output end_of_datagram, input ready);
  modport sink   (input valid, input data_byte, input end_of_datagram, output ready);
endinterface

/* rtl/dfr_out_if.sv */
// Result output channel: one decoded item or verdict per transaction.
interface dfr_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [63:0] value;
  logic [7:0]         field_count;
  logic [3:0]         status;
  logic               last_of_run;

  modport source (output valid, output kind, output value, output field_count,
                  output status, output last_of_run, input ready);
  modport sink   (input valid, input kind, input value, input field_count,
                  input status, input last_of_run, output ready);
endinterface

/* rtl/dfr_cfg_if.sv */
// Configuration write channel for the datagram length limit.
interface dfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [20:0] max_datagram_bytes;

  modport source (output valid, output max_datagram_bytes, input ready);
  modport sink   (input valid, input max_datagram_bytes, output ready);
endinterface

/* rtl/dfr_parser.sv */
// Byte parser: parse state registers and the combinational decode of one byte.
module dfr_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [20:0]   cfg_max_i,
  input  logic          in_vld_i,
  input  logic [7:0]    byte_i,
  input  logic          eod_i,
  output dfr_pkg::push_t push_o
);

  dfr_pkg::phase_e phase_q, phase_d;
  logic [20:0] max_q;
  logic [20:0] cnt_q, cnt_d;
  logic        batch_q, batch_d;
  logic        seen_q, seen_d;
  logic [15:0] sub_q, sub_d;
  logic [15:0] hdr_q, hdr_d;
  logic [7:0]  fl_q, fl_d;
  logic [2:0]  ft_q, ft_d;
  logic [63:0] acc_q, acc_d;
  logic [3:0]  vb_q, vb_d;
  logic [15:0] sl_q, sl_d;
  logic [3:0]  err_q, err_d;

  always_comb begin
    logic        in_sub;
    logic        pv;
    dfr_pkg::res_t pr;
    dfr_pkg::res_t vr;
    logic [15:0] w;
    logic [5:0]  shamt;
    logic [31:0] w32;
    logic [31:0] d32;
    logic [7:0]  fl_dec;
    dfr_pkg::status_e st;

    phase_d = phase_q;
    cnt_d   = cnt_q;
    batch_d = batch_q;
    seen_d  = seen_q;
    sub_d   = sub_q;
    hdr_d   = hdr_q;
    fl_d    = fl_q;
    ft_d    = ft_q;
    acc_d   = acc_q;
    vb_d    = vb_q;
    sl_d    = sl_q;
    err_d   = err_q;
    pv      = 1'b0;
    pr      = '0;
    vr      = '0;
    w       = '0;
    w32     = '0;
    d32     = '0;
    st      = dfr_pkg::StOk;
    shamt   = 6'(({2'b00, vb_q} << 3) - {2'b00, vb_q});
    fl_dec  = (fl_q != 8'd0) ? fl_q - 8'd1 : fl_q;
    in_sub  = 1'b0;

    if (in_vld_i) begin
      if (cnt_q != dfr_pkg::CountSat) begin
        cnt_d = cnt_q + 21'd1;
      end
      if (phase_q != dfr_pkg::PhDrop) begin
        in_sub = batch_q && (phase_q == dfr_pkg::PhPmag0 || phase_q == dfr_pkg::PhPmag1 ||
                 phase_q == dfr_pkg::PhOpc || phase_q == dfr_pkg::PhCnt ||
                 phase_q == dfr_pkg::PhFtype || phase_q == dfr_pkg::PhVar ||
                 phase_q == dfr_pkg::PhFloat || phase_q == dfr_pkg::PhSlen0 ||
                 phase_q == dfr_pkg::PhSlen1 || phase_q == dfr_pkg::PhSbytes ||
                 phase_q == dfr_pkg::PhDone);
        if (!batch_q && cnt_d > max_q &&
            (phase_q == dfr_pkg::PhOpc || phase_q == dfr_pkg::PhCnt ||
             phase_q == dfr_pkg::PhFtype || phase_q == dfr_pkg::PhVar ||
             phase_q == dfr_pkg::PhFloat || phase_q == dfr_pkg::PhSlen0 ||
             phase_q == dfr_pkg::PhSlen1 || phase_q == dfr_pkg::PhSbytes ||
             phase_q == dfr_pkg::PhDone)) begin
          err_d   = dfr_pkg::StBadLength;
          phase_d = dfr_pkg::PhDrop;
        end else begin
          unique case (phase_q)
            dfr_pkg::PhMag0: begin
              hdr_d   = {8'h00, byte_i};
              phase_d = dfr_pkg::PhMag1;
            end
            dfr_pkg::PhMag1: begin
              w     = {hdr_q[7:0], byte_i};
              hdr_d = w;
              if (w == dfr_pkg::MagicPacket) begin
                batch_d = 1'b0;
                phase_d = dfr_pkg::PhOpc;
                if (cnt_d > max_q) begin
                  err_d   = dfr_pkg::StBadLength;
                  phase_d = dfr_pkg::PhDrop;
                end
              end else if (w == dfr_pkg::MagicBatch) begin
                batch_d = 1'b1;
                phase_d = dfr_pkg::PhBlen0;
              end else begin
                err_d   = dfr_pkg::StBadMagic;
                phase_d = dfr_pkg::PhDrop;
              end
            end
            dfr_pkg::PhBlen0: begin
              sub_d   = {8'h00, byte_i};
              phase_d = dfr_pkg::PhBlen1;
            end
            dfr_pkg::PhBlen1: begin
              w     = {sub_q[7:0], byte_i};
              sub_d = w;
              if (w < 16'd4) begin
                err_d   = dfr_pkg::StBadLength;
                phase_d = dfr_pkg::PhDrop;
              end else begin
                phase_d = dfr_pkg::PhPmag0;
              end
            end
            dfr_pkg::PhPmag0: begin
              hdr_d   = {8'h00, byte_i};
              phase_d = dfr_pkg::PhPmag1;
            end
            dfr_pkg::PhPmag1: begin
              w     = {hdr_q[7:0], byte_i};
              hdr_d = w;
              if (w != dfr_pkg::MagicPacket) begin
                err_d   = dfr_pkg::StBadMagic;
                phase_d = dfr_pkg::PhDrop;
              end else begin
                phase_d = dfr_pkg::PhOpc;
              end
            end
            dfr_pkg::PhOpc: begin
              if (!dfr_pkg::opcode_ok(byte_i)) begin
                err_d   = dfr_pkg::StBadOpcode;
                phase_d = dfr_pkg::PhDrop;
              end else begin
                hdr_d   = {8'h00, byte_i};
                phase_d = dfr_pkg::PhCnt;
              end
            end
            dfr_pkg::PhCnt: begin
              fl_d           = byte_i;
              pv             = 1'b1;
              pr.kind        = dfr_pkg::KindPacket;
              pr.value       = {48'h0, hdr_q};
              pr.field_count = byte_i;
              phase_d        = (byte_i != 8'd0) ? dfr_pkg::PhFtype : dfr_pkg::PhDone;
            end
            dfr_pkg::PhFtype: begin
              acc_d = '0;
              vb_d  = '0;
              sl_d  = '0;
              case (byte_i)
                8'(dfr_pkg::FtInt32), 8'(dfr_pkg::FtInt64): begin
                  ft_d    = byte_i[2:0];
                  phase_d = dfr_pkg::PhVar;
                end
                8'(dfr_pkg::FtFloat): begin
                  ft_d    = byte_i[2:0];
                  phase_d = dfr_pkg::PhFloat;
                end
                8'(dfr_pkg::FtStr8), 8'(dfr_pkg::FtStr16): begin
                  ft_d    = byte_i[2:0];
                  phase_d = dfr_pkg::PhSlen0;
                end
                default: begin
                  err_d   = dfr_pkg::StBadType;
                  phase_d = dfr_pkg::PhDrop;
                end
              endcase
            end
            dfr_pkg::PhVar: begin
              if (vb_q < 4'd10) begin
                acc_d = acc_q | ({57'h0, byte_i[6:0]} << shamt);
              end
              vb_d = vb_q + 4'd1;
              if (!byte_i[7]) begin
                pv = 1'b1;
                if (ft_q == dfr_pkg::FtInt32) begin
                  w32      = acc_d[31:0];
                  d32      = (w32 >> 1) ^ {32{w32[0]}};
                  pr.kind  = dfr_pkg::KindInt32;
                  pr.value = {{32{d32[31]}}, d32};
                end else begin
                  pr.kind  = dfr_pkg::KindInt64;
                  pr.value = (acc_d >> 1) ^ {64{acc_d[0]}};
                end
                fl_d    = fl_dec;
                phase_d = (fl_dec != 8'd0) ? dfr_pkg::PhFtype : dfr_pkg::PhDone;
              end else if (vb_d >= 4'd10) begin
                err_d   = dfr_pkg::StOverlong;
                phase_d = dfr_pkg::PhDrop;
              end
            end
            dfr_pkg::PhFloat: begin
              acc_d = {32'h0, acc_q[23:0], byte_i};
              vb_d  = vb_q + 4'd1;
              if (vb_d >= 4'd4) begin
                pv       = 1'b1;
                pr.kind  = dfr_pkg::KindFloat;
                pr.value = acc_d;
                fl_d     = fl_dec;
                phase_d  = (fl_dec != 8'd0) ? dfr_pkg::PhFtype : dfr_pkg::PhDone;
              end
            end
            dfr_pkg::PhSlen0, dfr_pkg::PhSlen1: begin
              if (phase_q == dfr_pkg::PhSlen0) begin
                sl_d = {8'h00, byte_i};
              end else begin
                sl_d = {sl_q[7:0], byte_i};
              end
              if (phase_q == dfr_pkg::PhSlen0 && ft_q != dfr_pkg::FtStr8) begin
                phase_d = dfr_pkg::PhSlen1;
              end else begin
                pv       = 1'b1;
                pr.kind  = dfr_pkg::KindStrHead;
                pr.value = {48'h0, sl_d};
                if (sl_d != 16'd0) begin
                  phase_d = dfr_pkg::PhSbytes;
                end else begin
                  fl_d    = fl_dec;
                  phase_d = (fl_dec != 8'd0) ? dfr_pkg::PhFtype : dfr_pkg::PhDone;
                end
              end
            end
            dfr_pkg::PhSbytes: begin
              pv       = 1'b1;
              pr.kind  = dfr_pkg::KindStrByte;
              pr.value = {56'h0, byte_i};
              sl_d     = (sl_q != 16'd0) ? sl_q - 16'd1 : sl_q;
              if (sl_d == 16'd0) begin
                fl_d    = fl_dec;
                phase_d = (fl_dec != 8'd0) ? dfr_pkg::PhFtype : dfr_pkg::PhDone;
              end
            end
            dfr_pkg::PhDone: begin
              err_d   = dfr_pkg::StTrailing;
              phase_d = dfr_pkg::PhDrop;
            end
            default: begin
            end
          endcase
        end

        if (in_sub && phase_d != dfr_pkg::PhDrop) begin
          sub_d = (sub_q != 16'd0) ? sub_q - 16'd1 : sub_q;
          if (sub_d == 16'd0) begin
            if (phase_d == dfr_pkg::PhDone) begin
              seen_d  = 1'b1;
              phase_d = dfr_pkg::PhBlen0;
            end else begin
              err_d   = dfr_pkg::StTruncated;
              phase_d = dfr_pkg::PhDrop;
            end
          end
        end
      end

      if (eod_i) begin
        if (err_d != 4'(dfr_pkg::StOk)) begin
          st = dfr_pkg::status_e'(err_d);
        end else if (!batch_d && phase_d == dfr_pkg::PhDone) begin
          st = dfr_pkg::StOk;
        end else if (batch_d && phase_d == dfr_pkg::PhBlen0) begin
          st = seen_d ? dfr_pkg::StOk : dfr_pkg::StEmpty;
        end else begin
          st = dfr_pkg::StTruncated;
        end
        vr.kind        = dfr_pkg::KindVerdict;
        vr.status      = st;
        vr.last_of_run = 1'b1;
        phase_d = dfr_pkg::PhMag0;
        cnt_d   = '0;
        batch_d = 1'b0;
        seen_d  = 1'b0;
        sub_d   = '0;
        hdr_d   = '0;
        fl_d    = '0;
        ft_d    = '0;
        acc_d   = '0;
        vb_d    = '0;
        sl_d    = '0;
        err_d   = '0;
      end else begin
        pr.last_of_run = 1'b1;
      end
    end

    // parse result goes first, the verdict follows it
    push_o.vld0 = in_vld_i && (pv || eod_i);
    push_o.vld1 = in_vld_i && pv && eod_i;
    push_o.r0   = pv ? pr : vr;
    push_o.r1   = vr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dfr_pkg::PhMag0;
      max_q   <= dfr_pkg::MaxBytesRst;
      cnt_q   <= '0;
      batch_q <= 1'b0;
      seen_q  <= 1'b0;
      sub_q   <= '0;
      hdr_q   <= '0;
      fl_q    <= '0;
      ft_q    <= '0;
      acc_q   <= '0;
      vb_q    <= '0;
      sl_q    <= '0;
      err_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      batch_q <= batch_d;
      seen_q  <= seen_d;
      sub_q   <= sub_d;
      hdr_q   <= hdr_d;
      fl_q    <= fl_d;
      ft_q    <= ft_d;
      acc_q   <= acc_d;
      vb_q    <= vb_d;
      sl_q    <= sl_d;
      err_q   <= err_d;
      if (cfg_we_i) begin
        max_q <= cfg_max_i;
      end
    end
  end

endmodule

/* rtl/dfr_result_fifo.sv */
// Result queue: takes up to two results per cycle, hands out one per transaction.
module dfr_result_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dfr_pkg::push_t push_i,
  output logic           space_o,
  output logic           valid_o,
  input  logic           ready_i,
  output dfr_pkg::res_t  res_o
);

  localparam int unsigned PtrW = dfr_pkg::ResPtrW;
  localparam int unsigned CntW = PtrW + 1;

  dfr_pkg::res_t mem_q [dfr_pkg::ResDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic [1:0]      n_push;
  logic            pop;

  assign n_push  = 2'(push_i.vld0) + 2'(push_i.vld1);
  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign res_o   = mem_q[rd_q];
  assign space_o = (cnt_q <= CntW'(dfr_pkg::ResDepth - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.vld0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.vld1) begin
      mem_q[wr_q + PtrW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(n_push);
      rd_q  <= rd_q + PtrW'(pop);
      cnt_q <= cnt_q + CntW'(n_push) - CntW'(pop);
    end
  end

endmodule

/* rtl/typed_field_packet_deframer.sv */
// Typed-field packet deframer top level: byte parser feeding a result queue.
// Takes one datagram byte per cycle while input ready is high and decodes it
// in the same cycle; its results (at most two per byte) land in a four-entry
// result queue, whose registers drive the output. Input ready is low only
// while the queue holds more than two results, so with the output taking
// one result per cycle the block sustains one byte per cycle; a byte that
// gives two results (a decoded value plus the verdict) pushes both at once.
// Configuration writes are always ready and are registered into the limit.
module typed_field_packet_deframer (
  input  logic      clk_i,
  input  logic      rst_ni,
  dfr_in_if.sink    item_i,
  dfr_out_if.source result_o,
  dfr_cfg_if.sink   cfg_i
);

  dfr_pkg::push_t push;
  dfr_pkg::res_t  res;
  logic           space;
  logic           in_acc;

  assign item_i.ready = space;
  assign cfg_i.ready  = 1'b1;
  assign in_acc       = item_i.valid && space;

  dfr_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_i.valid),
    .cfg_max_i (cfg_i.max_datagram_bytes),
    .in_vld_i  (in_acc),
    .byte_i    (item_i.data_byte),
    .eod_i     (item_i.end_of_datagram),
    .push_o    (push)
  );

  dfr_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .valid_o (result_o.valid),
    .ready_i (result_o.ready),
    .res_o   (res)
  );

  assign result_o.kind        = res.kind;
  assign result_o.value       = $signed(res.value);
  assign result_o.field_count = res.field_count;
  assign result_o.status      = res.status;
  assign result_o.last_of_run = res.last_of_run;

endmodule

/* test/tb_typed_field_packet_deframer.sv */
// Testbench for the typed-field packet deframer: directed and random datagrams.
`timescale 1ns / 1ps
module tb_typed_field_packet_deframer;

  localparam int SubMin = 4;
  localparam int VarintMax = 10;

  typedef logic [7:0] bytes_t[$];

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #2 clk_i = ~clk_i;

  dfr_in_if  in_if();
  dfr_out_if out_if();
  dfr_cfg_if cfg_if();

  typed_field_packet_deframer i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_if),
    .result_o (out_if),
    .cfg_i    (cfg_if)
  );

  // decoder state
  logic [20:0]      len_limit;
  dfr_pkg::phase_e  ph;
  logic [20:0]      dg_cnt;
  logic             in_batch;
  logic             got_packet;
  logic [15:0]      sub_left;
  logic [15:0]      hdr;
  logic [7:0]       flds_left;
  dfr_pkg::ftype_e  cur_type;
  logic [63:0]      var_acc;
  logic [3:0]       var_cnt;
  logic [15:0]      str_left;
  dfr_pkg::status_e err;

  dfr_pkg::res_t decoded_q[$];
  int   n_step;
  int   mismatches = 0;
  int   results_seen = 0;
  int   bytes_sent = 0;
  int   datagrams = 0;
  int   limit_writes = 0;
  int   burst_left = 0;
  logic in_hold = 1'b0;
  int   rx_tick = 0;
  int   rx_stall_pct = 0;

  function automatic logic opcode_known(logic [7:0] id);
    return id inside {[1:6], [10:16], [20:34], [40:46], [60:86], [90:94]};
  endfunction

  function automatic void clear_parse();
    ph = dfr_pkg::PhMag0;
    dg_cnt = '0;
    in_batch = 1'b0;
    got_packet = 1'b0;
    sub_left = '0;
    hdr = '0;
    flds_left = '0;
    cur_type = dfr_pkg::FtStr8;
    var_acc = '0;
    var_cnt = '0;
    str_left = '0;
    err = dfr_pkg::StOk;
  endfunction

  function automatic void emit(dfr_pkg::kind_e k, logic [63:0] v, logic [7:0] fc,
                               dfr_pkg::status_e st);
    dfr_pkg::res_t r;
    r.kind = k;
    r.value = v;
    r.field_count = fc;
    r.status = st;
    r.last_of_run = 1'b0;
    decoded_q = {decoded_q, r};
    n_step++;
  endfunction

  function automatic void flag_error(dfr_pkg::status_e code);
    if (err == dfr_pkg::StOk) err = code;
    ph = dfr_pkg::PhDrop;
  endfunction

  function automatic void field_done();
    if (flds_left != 0) flds_left--;
    if (flds_left != 0) ph = dfr_pkg::PhFtype;
    else ph = dfr_pkg::PhDone;
  endfunction

  function automatic void string_start();
    emit(dfr_pkg::KindStrHead, 64'(str_left), 8'd0, dfr_pkg::StOk);
    if (str_left != 0) ph = dfr_pkg::PhSbytes;
    else field_done();
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    logic [31:0] w;
    logic [31:0] d32;
    case (ph)
      dfr_pkg::PhMag0: begin
        hdr = 16'(b);
        ph = dfr_pkg::PhMag1;
      end
      dfr_pkg::PhMag1: begin
        hdr = {hdr[7:0], b};
        if (hdr == dfr_pkg::MagicPacket) begin
          in_batch = 1'b0;
          ph = dfr_pkg::PhOpc;
          if (dg_cnt > len_limit) flag_error(dfr_pkg::StBadLength);
        end else if (hdr == dfr_pkg::MagicBatch) begin
          in_batch = 1'b1;
          ph = dfr_pkg::PhBlen0;
        end else begin
          flag_error(dfr_pkg::StBadMagic);
        end
      end
      dfr_pkg::PhBlen0: begin
        sub_left = 16'(b);
        ph = dfr_pkg::PhBlen1;
      end
      dfr_pkg::PhBlen1: begin
        sub_left = {sub_left[7:0], b};
        if (sub_left < SubMin) flag_error(dfr_pkg::StBadLength);
        else ph = dfr_pkg::PhPmag0;
      end
      dfr_pkg::PhPmag0: begin
        hdr = 16'(b);
        ph = dfr_pkg::PhPmag1;
      end
      dfr_pkg::PhPmag1: begin
        hdr = {hdr[7:0], b};
        if (hdr != dfr_pkg::MagicPacket) flag_error(dfr_pkg::StBadMagic);
        else ph = dfr_pkg::PhOpc;
      end
      dfr_pkg::PhOpc: begin
        if (!opcode_known(b)) begin
          flag_error(dfr_pkg::StBadOpcode);
        end else begin
          hdr = 16'(b);
          ph = dfr_pkg::PhCnt;
        end
      end
      dfr_pkg::PhCnt: begin
        flds_left = b;
        emit(dfr_pkg::KindPacket, 64'(hdr), b, dfr_pkg::StOk);
        if (b != 0) ph = dfr_pkg::PhFtype;
        else ph = dfr_pkg::PhDone;
      end
      dfr_pkg::PhFtype: begin
        var_acc = '0;
        var_cnt = '0;
        str_left = '0;
        if (b == 8'(dfr_pkg::FtInt32) || b == 8'(dfr_pkg::FtInt64)) begin
          cur_type = dfr_pkg::ftype_e'(b[2:0]);
          ph = dfr_pkg::PhVar;
        end else if (b == 8'(dfr_pkg::FtFloat)) begin
          cur_type = dfr_pkg::FtFloat;
          ph = dfr_pkg::PhFloat;
        end else if (b == 8'(dfr_pkg::FtStr8) || b == 8'(dfr_pkg::FtStr16)) begin
          cur_type = dfr_pkg::ftype_e'(b[2:0]);
          ph = dfr_pkg::PhSlen0;
        end else begin
          flag_error(dfr_pkg::StBadType);
        end
      end
      dfr_pkg::PhVar: begin
        if (var_cnt < VarintMax) var_acc |= 64'(b[6:0]) << (7 * var_cnt);
        var_cnt++;
        if (!b[7]) begin
          if (cur_type == dfr_pkg::FtInt32) begin
            w = var_acc[31:0];
            d32 = (w >> 1) ^ {32{w[0]}};
            emit(dfr_pkg::KindInt32, {{32{d32[31]}}, d32}, 8'd0, dfr_pkg::StOk);
          end else begin
            emit(dfr_pkg::KindInt64, (var_acc >> 1) ^ {64{var_acc[0]}}, 8'd0,
                 dfr_pkg::StOk);
          end
          field_done();
        end else if (var_cnt >= VarintMax) begin
          flag_error(dfr_pkg::StOverlong);
        end
      end
      dfr_pkg::PhFloat: begin
        var_acc = {32'd0, var_acc[23:0], b};
        var_cnt++;
        if (var_cnt >= 4) begin
          emit(dfr_pkg::KindFloat, var_acc, 8'd0, dfr_pkg::StOk);
          field_done();
        end
      end
      dfr_pkg::PhSlen0: begin
        str_left = 16'(b);
        if (cur_type == dfr_pkg::FtStr8) string_start();
        else ph = dfr_pkg::PhSlen1;
      end
      dfr_pkg::PhSlen1: begin
        str_left = {str_left[7:0], b};
        string_start();
      end
      dfr_pkg::PhSbytes: begin
        emit(dfr_pkg::KindStrByte, 64'(b), 8'd0, dfr_pkg::StOk);
        if (str_left != 0) str_left--;
        if (str_left == 0) field_done();
      end
      dfr_pkg::PhDone: flag_error(dfr_pkg::StTrailing);
      default: ;
    endcase
  endfunction

  function automatic void deframe_byte(logic [7:0] b, logic eod);
    logic             sub_active;
    dfr_pkg::status_e st;
    dfr_pkg::res_t    r;
    n_step = 0;
    if (dg_cnt < dfr_pkg::CountSat) dg_cnt++;
    if (ph != dfr_pkg::PhDrop) begin
      sub_active = in_batch && ph >= dfr_pkg::PhPmag0 && ph <= dfr_pkg::PhDone;
      if (!in_batch && ph >= dfr_pkg::PhOpc && ph <= dfr_pkg::PhDone && dg_cnt > len_limit)
        flag_error(dfr_pkg::StBadLength);
      else
        parse_byte(b);
      if (sub_active && ph != dfr_pkg::PhDrop) begin
        if (sub_left != 0) sub_left--;
        if (sub_left == 0) begin
          if (ph == dfr_pkg::PhDone) begin
            got_packet = 1'b1;
            ph = dfr_pkg::PhBlen0;
          end else begin
            flag_error(dfr_pkg::StTruncated);
          end
        end
      end
    end
    if (eod) begin
      if (err != dfr_pkg::StOk) st = err;
      else if (!in_batch && ph == dfr_pkg::PhDone) st = dfr_pkg::StOk;
      else if (in_batch && ph == dfr_pkg::PhBlen0) begin
        if (got_packet) st = dfr_pkg::StOk;
        else st = dfr_pkg::StEmpty;
      end else st = dfr_pkg::StTruncated;
      emit(dfr_pkg::KindVerdict, 64'd0, 8'd0, st);
      clear_parse();
    end
    if (n_step > 0) begin
      r = decoded_q.pop_back();
      r.last_of_run = 1'b1;
      decoded_q = {decoded_q, r};
    end
  endfunction

  function automatic void cmp_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // result checker and output stall pattern
  always @(posedge clk_i) begin
    dfr_pkg::res_t want;
    if (out_if.valid && out_if.ready) begin
      results_seen++;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected transaction: expected none, actual kind %0d value %h",
                 $time, out_if.kind, out_if.value);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        cmp_field("kind", 64'(want.kind), 64'(out_if.kind));
        cmp_field("value", want.value, out_if.value);
        cmp_field("field_count", 64'(want.field_count), 64'(out_if.field_count));
        cmp_field("status", 64'(want.status), 64'(out_if.status));
        cmp_field("last_of_run", 64'(want.last_of_run), 64'(out_if.last_of_run));
      end
    end
    rx_tick++;
    if (rx_tick % 150 == 0) begin
      case ($urandom_range(0, 3))
        0: rx_stall_pct = 0;
        1: rx_stall_pct = 20;
        2: rx_stall_pct = 50;
        default: rx_stall_pct = 85;
      endcase
    end
    out_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  task automatic send_byte(logic [7:0] b, logic eod);
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.end_of_datagram <= eod;
    do @(posedge clk_i); while (!in_if.ready);
    deframe_byte(b, eod);
    bytes_sent++;
    if (burst_left > 0) begin
      burst_left--;
      in_hold = 1'b1;
    end else begin
      in_if.valid <= 1'b0;
      in_hold = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 10);
    end
  endtask

  task automatic send_datagram(bytes_t dg);
    foreach (dg[i]) send_byte(dg[i], i == dg.size() - 1);
    datagrams++;
  endtask

  task automatic wait_quiet();
    if (in_hold) begin
      in_if.valid <= 1'b0;
      in_hold = 1'b0;
    end
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_length_limit(logic [20:0] v);
    wait_quiet();
    cfg_if.valid <= 1'b1;
    cfg_if.max_datagram_bytes <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    len_limit = v;
    limit_writes++;
    cfg_if.valid <= 1'b0;
  endtask

  function automatic bytes_t pkt_head(logic [7:0] op, logic [7:0] nf);
    bytes_t q;
    q = {dfr_pkg::MagicPacket[15:8], dfr_pkg::MagicPacket[7:0], op, nf};
    return q;
  endfunction

  function automatic void put_varint(ref bytes_t q, input logic [63:0] v);
    logic [7:0] nb;
    do begin
      nb = {(v >> 7) != 0, v[6:0]};
      q = {q, nb};
      v = v >> 7;
    end while (v != 0);
  endfunction

  function automatic void put_field(ref bytes_t q);
    int          sel;
    int          len;
    logic [63:0] v;
    logic [7:0]  nb;
    sel = $urandom_range(0, 9);
    v = {$urandom, $urandom} >> $urandom_range(0, 64);
    case (sel)
      0, 1, 2: begin
        q = {q, 8'(dfr_pkg::FtInt32)};
        put_varint(q, v);
      end
      3, 4: begin
        q = {q, 8'(dfr_pkg::FtInt64)};
        put_varint(q, v);
      end
      5: begin
        q = {q, 8'(dfr_pkg::FtFloat)};
        repeat (4) q = {q, 8'($urandom)};
      end
      6, 7: begin
        len = $urandom_range(0, 6);
        q = {q, 8'(dfr_pkg::FtStr8), 8'(len)};
        repeat (len) q = {q, 8'($urandom)};
      end
      8: begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(250, 270) : $urandom_range(0, 6);
        q = {q, 8'(dfr_pkg::FtStr16), 8'(len >> 8), 8'(len)};
        repeat (len) q = {q, 8'($urandom)};
      end
      default: begin
        // full-length varint: the last byte keeps only its low payload bit
        nb = $urandom_range(0, 1) ? 8'(dfr_pkg::FtInt32) : 8'(dfr_pkg::FtInt64);
        q = {q, nb};
        repeat (VarintMax - 1) begin
          nb = {1'b1, 7'($urandom)};
          q = {q, nb};
        end
        nb = {1'b0, 7'($urandom)};
        q = {q, nb};
      end
    endcase
  endfunction

  function automatic void put_packet(ref bytes_t q);
    int         nf;
    logic [7:0] op;
    nf = $urandom_range(0, 4);
    do op = 8'($urandom); while (!opcode_known(op));
    q = {q, dfr_pkg::MagicPacket[15:8], dfr_pkg::MagicPacket[7:0], op, 8'(nf)};
    repeat (nf) put_field(q);
  endfunction

  function automatic bytes_t random_datagram();
    bytes_t dg;
    bytes_t pkt;
    int     form;
    int     flaw;
    int     plen;
    form = $urandom_range(0, 99);
    flaw = $urandom_range(0, 6);
    if (form < 40 || (form >= 75 && flaw == 6)) begin
      put_packet(dg);
    end else begin
      dg = {dfr_pkg::MagicBatch[15:8], dfr_pkg::MagicBatch[7:0]};
      repeat ($urandom_range(1, 3)) begin
        pkt = {};
        put_packet(pkt);
        plen = pkt.size();
        if (form >= 75 && flaw == 5) plen = plen + $urandom_range(0, 6) - 3;
        dg = {dg, 8'(plen >> 8), 8'(plen)};
        dg = {dg, pkt};
      end
    end
    if (form >= 75) begin
      case (flaw)
        0: dg = dg[0 : $urandom_range(0, dg.size() - 2)];
        1: dg[$urandom_range(0, dg.size() - 1)] = 8'($urandom);
        2: repeat ($urandom_range(1, 3)) dg = {dg, 8'($urandom)};
        3: begin
          dg = {};
          repeat ($urandom_range(1, 8)) dg = {dg, 8'($urandom)};
        end
        4: dg = {dfr_pkg::MagicBatch[15:8], dfr_pkg::MagicBatch[7:0]};
        6: dg[3] = 8'($urandom);
        default: ;
      endcase
    end
    return dg;
  endfunction

  task automatic test_field_decode();
    bytes_t dg;
    send_datagram(pkt_head(8'd1, 8'd0));
    dg = pkt_head(8'd94, 8'd5);
    dg = {dg, 8'(dfr_pkg::FtInt32), 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'(dfr_pkg::FtInt64)};
    repeat (9) dg = {dg, 8'hFF};
    dg = {dg, 8'h01, 8'(dfr_pkg::FtFloat), 8'h00, 8'hFF, 8'h80, 8'h7F, 8'(dfr_pkg::FtStr8),
          8'h02, 8'h00, 8'hFF, 8'(dfr_pkg::FtStr16), 8'h00, 8'h01, 8'hAA};
    send_datagram(dg);
    // int32 loses varint bits above 31; tenth byte keeps only bit 0
    dg = pkt_head(8'd60, 8'd2);
    dg = {dg, 8'(dfr_pkg::FtInt32), 8'h80, 8'h80, 8'h80, 8'h80, 8'h10, 8'(dfr_pkg::FtInt64)};
    repeat (9) dg = {dg, 8'hFF};
    dg = {dg, 8'h7E};
    send_datagram(dg);
    dg = pkt_head(8'd10, 8'd1);
    dg = {dg, 8'(dfr_pkg::FtStr16), 8'h01, 8'h00};
    repeat (256) dg = {dg, 8'($urandom)};
    send_datagram(dg);
  endtask

  task automatic test_parse_errors();
    bytes_t dg;
    send_datagram({dfr_pkg::MagicPacket[15:8], 8'h33, 8'h01, 8'h00});
    send_datagram(pkt_head(8'd0, 8'd0));
    dg = pkt_head(8'hFF, 8'd1);
    dg = {dg, 8'(dfr_pkg::FtInt32), 8'h00};
    send_datagram(dg);
    dg = pkt_head(8'd1, 8'd1);
    dg = {dg, 8'h05, 8'h00};
    send_datagram(dg);
    dg = pkt_head(8'd1, 8'd1);
    dg = {dg, 8'hFF};
    send_datagram(dg);
    dg = pkt_head(8'd1, 8'd1);
    dg = {dg, 8'(dfr_pkg::FtInt64)};
    repeat (VarintMax) dg = {dg, 8'hFF};
    dg = {dg, 8'h00};
    send_datagram(dg);
    dg = pkt_head(8'd1, 8'd2);
    dg = {dg, 8'(dfr_pkg::FtInt32), 8'h05};
    send_datagram(dg);
    send_datagram({dfr_pkg::MagicPacket[15:8]});
    dg = pkt_head(8'd1, 8'hFF);
    dg = {dg, 8'(dfr_pkg::FtFloat), 8'h01, 8'h02};
    send_datagram(dg);
    dg = pkt_head(8'd1, 8'd0);
    dg = {dg, 8'h00, 8'hFF};
    send_datagram(dg);
  endtask

  task automatic test_batches();
    bytes_t dg;
    send_datagram({dfr_pkg::MagicBatch[15:8], dfr_pkg::MagicBatch[7:0]});
    dg = {dfr_pkg::MagicBatch[15:8], dfr_pkg::MagicBatch[7:0], 8'h00, 8'h03};
    dg = {dg, pkt_head(8'd1, 8'd0)};
    send_datagram(dg);
    dg = {dfr_pkg::MagicBatch[15:8], dfr_pkg::MagicBatch[7:0], 8'h00, 8'h04};
    dg = {dg, pkt_head(8'd1, 8'd1)};
    dg = {dg, 8'(dfr_pkg::FtFloat), 8'h00, 8'h00, 8'h00, 8'h00};
    send_datagram(dg);
    dg = {dfr_pkg::MagicBatch[15:8], dfr_pkg::MagicBatch[7:0], 8'h00, 8'h04};
    dg = {dg, pkt_head(8'd2, 8'd0)};
    dg = {dg, 8'h00, 8'h06};
    dg = {dg, pkt_head(8'd20, 8'd1)};
    dg = {dg, 8'(dfr_pkg::FtInt32), 8'h03};
    send_datagram(dg);
    dg = {dfr_pkg::MagicBatch[15:8], dfr_pkg::MagicBatch[7:0], 8'h00, 8'h04};
    dg = {dg, pkt_head(8'd1, 8'd0)};
    dg = {dg, 8'h00};
    send_datagram(dg);
    dg = {dfr_pkg::MagicBatch[15:8], dfr_pkg::MagicBatch[7:0], 8'h00, 8'h04,
          dfr_pkg::MagicBatch[15:8], dfr_pkg::MagicBatch[7:0], 8'h01, 8'h00};
    send_datagram(dg);
    dg = {dfr_pkg::MagicBatch[15:8], dfr_pkg::MagicBatch[7:0], 8'h00, 8'h05};
    dg = {dg, pkt_head(8'd1, 8'd0)};
    dg = {dg, 8'h00};
    send_datagram(dg);
  endtask

  task automatic test_length_limit();
    bytes_t dg;
    set_length_limit(21'd4);
    send_datagram(pkt_head(8'd1, 8'd0));
    dg = pkt_head(8'd1, 8'd1);
    dg = {dg, 8'(dfr_pkg::FtInt32), 8'h00};
    send_datagram(dg);
    dg = {dfr_pkg::MagicBatch[15:8], dfr_pkg::MagicBatch[7:0], 8'h00, 8'h06};
    dg = {dg, pkt_head(8'd3, 8'd1)};
    dg = {dg, 8'(dfr_pkg::FtInt64), 8'h7F};
    send_datagram(dg);
    set_length_limit(21'd3);
    send_datagram(pkt_head(8'd1, 8'd0));
    set_length_limit(21'd0);
    send_datagram(pkt_head(8'd1, 8'd0));
    set_length_limit(dfr_pkg::MaxBytesRst);
    send_datagram(pkt_head(8'd1, 8'd0));
  endtask

  task automatic test_random_traffic();
    logic [20:0] limits[5];
    int          start;
    limits = '{dfr_pkg::MaxBytesRst, 21'd24, 21'd60, 21'd8, dfr_pkg::MaxBytesRst};
    foreach (limits[k]) begin
      set_length_limit(limits[k]);
      start = bytes_sent;
      while (bytes_sent - start < 12) send_datagram(random_datagram());
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.end_of_datagram = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.max_datagram_bytes = '0;
    len_limit = dfr_pkg::MaxBytesRst;
    clear_parse();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_decode();
    test_parse_errors();
    test_batches();
    test_length_limit();
    test_random_traffic();
    wait_quiet();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d datagrams (%0d bytes) across %0d length limit settings",
             datagrams, bytes_sent, limit_writes);
    $display("Checked %0d result transactions, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("PASS typed_field_packet_deframer");
    end else begin
      $display("FAIL typed_field_packet_deframer");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", decoded_q.size());
    $display("FAIL typed_field_packet_deframer");
    $finish;
  end

endmodule

/* typed_field_packet_deframer.f */
rtl/dfr_pkg.sv
rtl/dfr_in_if.sv
rtl/dfr_out_if.sv
rtl/dfr_cfg_if.sv
rtl/dfr_parser.sv
rtl/dfr_result_fifo.sv
rtl/typed_field_packet_deframer.sv
test/tb_typed_field_packet_deframer.sv
